@@ sv/bfla_pkg.sv @@
`timescale 1ns / 1ps
package bfla_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 12;
  localparam int MIN_ALIGN    = 4;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ALIGN_W      = 17;
  localparam int IN_DATA_W    = 88;
  localparam int OUT_DATA_W   = 200;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES = 2'd1;

  typedef enum logic [2:0] {
    ACT_ALLOC    = 3'd0,
    ACT_FREE     = 3'd1,
    ACT_RESET    = 3'd2,
    ACT_QUERY    = 3'd3,
    ACT_CONTAINS = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_OOM     = 3'd2,
    ST_FULL    = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    setup_align;
    logic    ptr_down;
    logic    ptr_up;
    logic    ptr_clear;
    logic    stk_rd_scan;
    logic    tbl_rd_stk;
    logic    tbl_rd_ptr;
    logic    reuse_wb;
    logic    shift_rd;
    logic    shift_wr;
    logic    shift_end;
    logic    bump_end;
    logic    bump_wb;
    logic    free_wb;
    logic    pool_reset;
    logic    contains;
    logic    st_set;
    status_t st_code;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] action;
    logic       size_zero;
    logic       addr_zero;
    logic       ptr_zero;
    logic       fit;
    logic       shift_done;
    logic       oom;
    logic       table_full;
    logic       ptr_at_end;
    logic       fmatch;
    logic       stack_full;
  } dp_sts_t;

  // smallest all-ones mask covering v
  function automatic logic [ALIGN_W-1:0] smear(input logic [ALIGN_W-1:0] v);
    logic [ALIGN_W-1:0] r;
    r = v;
    r = r | (r >> 1);
    r = r | (r >> 2);
    r = r | (r >> 4);
    r = r | (r >> 8);
    r = r | (r >> 16);
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic [32:0] v);
    return v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

@@ sv/bfla_ctrl.sv @@
`timescale 1ns / 1ps
module bfla_ctrl import bfla_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  output logic    cfg_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DECODE   = 14'b00000000000010,
    S_ASCAN    = 14'b00000000000100,
    S_ASTK     = 14'b00000000001000,
    S_ABLK     = 14'b00000000010000,
    S_REUSE    = 14'b00000000100000,
    S_SHIFT_RD = 14'b00000001000000,
    S_SHIFT_WR = 14'b00000010000000,
    S_BUMP     = 14'b00000100000000,
    S_BCHK     = 14'b00001000000000,
    S_FSCAN    = 14'b00010000000000,
    S_FCHK     = 14'b00100000000000,
    S_FWB      = 14'b01000000000000,
    S_OUT      = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.st_code = ST_OK;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_OUT;
        case (sts.action)
          ACT_ALLOC: begin
            if (sts.size_zero) begin
              cmd.st_set = 1'b1;
              cmd.st_code = ST_ZERO;
            end else begin
              cmd.setup_align = 1'b1;
              state_next = S_ASCAN;
            end
          end
          ACT_FREE: begin
            if (sts.addr_zero) begin
              cmd.st_set = 1'b1;
              cmd.st_code = ST_IGNORED;
            end else begin
              cmd.ptr_clear = 1'b1;
              state_next = S_FSCAN;
            end
          end
          ACT_RESET:    cmd.pool_reset = 1'b1;
          ACT_CONTAINS: cmd.contains = 1'b1;
          default: ;
        endcase
      end
      S_ASCAN: begin
        if (sts.ptr_zero) begin
          state_next = S_BUMP;
        end else begin
          cmd.stk_rd_scan = 1'b1;
          state_next = S_ASTK;
        end
      end
      S_ASTK: begin
        cmd.tbl_rd_stk = 1'b1;
        state_next = S_ABLK;
      end
      S_ABLK: begin
        if (sts.fit) begin
          state_next = S_REUSE;
        end else begin
          cmd.ptr_down = 1'b1;
          state_next = S_ASCAN;
        end
      end
      S_REUSE: begin
        cmd.reuse_wb = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (sts.shift_done) begin
          cmd.shift_end = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_BUMP: begin
        cmd.bump_end = 1'b1;
        state_next = S_BCHK;
      end
      S_BCHK: begin
        if (sts.oom) begin
          cmd.st_set = 1'b1;
          cmd.st_code = ST_OOM;
        end else if (sts.table_full) begin
          cmd.st_set = 1'b1;
          cmd.st_code = ST_FULL;
        end else begin
          cmd.bump_wb = 1'b1;
        end
        state_next = S_OUT;
      end
      S_FSCAN: begin
        if (sts.ptr_at_end) begin
          cmd.st_set = 1'b1;
          cmd.st_code = ST_IGNORED;
          state_next = S_OUT;
        end else begin
          cmd.tbl_rd_ptr = 1'b1;
          state_next = S_FCHK;
        end
      end
      S_FCHK: begin
        if (sts.fmatch) begin
          if (sts.stack_full) begin
            cmd.st_set = 1'b1;
            cmd.st_code = ST_IGNORED;
            state_next = S_OUT;
          end else begin
            state_next = S_FWB;
          end
        end else begin
          cmd.ptr_up = 1'b1;
          state_next = S_FSCAN;
        end
      end
      S_FWB: begin
        cmd.free_wb = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/bfla_dp.sv @@
`timescale 1ns / 1ps
module bfla_dp import bfla_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [2:0]            s_tuser,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [2:0]            m_tuser
);

  // configuration and pool state
  logic [31:0] pool_base, pool_bytes, lim_r;
  logic [31:0] bump, allocated, peak, allocs, frees, listed;
  logic [MAX_BLOCKS-1:0] live;
  logic [CNT_W-1:0] blocks_used, free_depth, ptr;

  // current item
  logic [2:0]         action_r;
  logic [31:0]        size_r, address_r;
  logic [ALIGN_W-1:0] pmask_r;
  logic [32:0]        rsize_r;
  logic [33:0]        user_r, end_r;
  status_t            status_r;
  logic [31:0]        res_r;
  logic               inside_r;

  // memories
  logic [31:0]      tbl_addr_mem [MAX_BLOCKS];
  logic [31:0]      tbl_size_mem [MAX_BLOCKS];
  logic [IDX_W-1:0] stk_mem      [MAX_BLOCKS];
  logic [31:0]      tbl_addr_q, tbl_size_q;
  logic [IDX_W-1:0] stk_q;

  logic [ALIGN_W-1:0] align_in, align_eff, mask_in;
  logic [32:0] lim_sum, rsize_c;
  logic [33:0] user_c;
  logic [31:0] nb, bump_n, add_n, inuse_sum, fs_b, free_space_c;
  logic        cfg_hit, do_reset, contains_c, reclaim;
  logic [IDX_W-1:0] tbl_ra, stk_ra, stk_wa, stk_wd;
  logic [CNT_W-1:0] ptr_m1, ptr_p1;

  assign align_in  = s_tdata[48:32];
  assign align_eff = (align_in < ALIGN_W'(MIN_ALIGN)) ? ALIGN_W'(MIN_ALIGN) : align_in;
  assign mask_in   = smear(align_eff - 1'b1);

  assign lim_sum = {1'b0, pool_base} + {1'b0, pool_bytes};
  assign rsize_c = ({1'b0, size_r} + {16'b0, pmask_r}) & ~{16'b0, pmask_r};
  assign user_c  = ({2'b0, bump} + 34'(HEADER_BYTES) + {17'b0, pmask_r})
                   & ~{17'b0, pmask_r};

  assign nb        = sat32({1'b0, tbl_size_q} + 33'(HEADER_BYTES));
  assign bump_n    = end_r[31:0] - bump;
  assign add_n     = cmd.reuse_wb ? nb : bump_n;
  assign inuse_sum = sat32({1'b0, allocated} + {1'b0, add_n});

  assign fs_b         = (bump < lim_r) ? (lim_r - bump) : 32'd0;
  assign free_space_c = sat32({1'b0, fs_b} + {1'b0, listed});
  assign contains_c   = (address_r != 32'd0) && (address_r >= pool_base) &&
                        ({1'b0, address_r} < lim_sum);

  assign cfg_hit  = cfg_wr && (cfg_index == REG_POOL_BASE || cfg_index == REG_POOL_BYTES);
  assign do_reset = cfg_hit || cmd.pool_reset;
  assign reclaim  = (frees + 32'd1) == allocs;

  assign ptr_m1 = ptr - 1'b1;
  assign ptr_p1 = ptr + 1'b1;

  always_comb begin
    sts.action     = action_r;
    sts.size_zero  = (size_r == 32'd0);
    sts.addr_zero  = (address_r == 32'd0);
    sts.ptr_zero   = (ptr == '0);
    sts.fit        = ({1'b0, tbl_size_q} >= rsize_r) &&
                     ((tbl_addr_q[ALIGN_W-1:0] & pmask_r) == '0);
    sts.shift_done = (ptr_p1 >= free_depth);
    sts.oom        = end_r > {2'b0, lim_r};
    sts.table_full = blocks_used >= CNT_W'(MAX_BLOCKS);
    sts.ptr_at_end = ptr >= blocks_used;
    sts.fmatch     = live[ptr[IDX_W-1:0]] && (tbl_addr_q == address_r);
    sts.stack_full = free_depth >= CNT_W'(MAX_BLOCKS);
  end

  // block table: written at the bump index, read at a stack entry or the scan pointer
  assign tbl_ra = cmd.tbl_rd_stk ? stk_q : ptr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.bump_wb) begin
      tbl_addr_mem[blocks_used[IDX_W-1:0]] <= user_r[31:0];
      tbl_size_mem[blocks_used[IDX_W-1:0]] <= rsize_r[31:0];
    end
    if (cmd.tbl_rd_stk || cmd.tbl_rd_ptr) begin
      tbl_addr_q <= tbl_addr_mem[tbl_ra];
      tbl_size_q <= tbl_size_mem[tbl_ra];
    end
  end

  // free stack
  assign stk_ra = cmd.stk_rd_scan ? ptr_m1[IDX_W-1:0] : ptr_p1[IDX_W-1:0];
  assign stk_wa = cmd.free_wb ? free_depth[IDX_W-1:0] : ptr[IDX_W-1:0];
  assign stk_wd = cmd.free_wb ? ptr[IDX_W-1:0] : stk_q;

  always_ff @(posedge clk) begin
    if (cmd.free_wb || cmd.shift_wr) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cmd.stk_rd_scan || cmd.shift_rd) begin
      stk_q <= stk_mem[stk_ra];
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    lim_r <= sat32(lim_sum);
    if (cmd.load) begin
      action_r  <= s_tuser;
      size_r    <= s_tdata[31:0];
      address_r <= s_tdata[80:49];
      pmask_r   <= mask_in;
      status_r  <= ST_OK;
      res_r     <= 32'd0;
      inside_r  <= 1'b0;
    end
    if (cmd.setup_align) begin
      rsize_r <= rsize_c;
      user_r  <= user_c;
    end
    if (cmd.bump_end) begin
      end_r <= user_r + {1'b0, rsize_r};
    end
    if (cmd.st_set) begin
      status_r <= cmd.st_code;
    end
    if (cmd.reuse_wb) begin
      res_r <= tbl_addr_q;
    end
    if (cmd.bump_wb) begin
      res_r <= user_r[31:0];
    end
    if (cmd.contains) begin
      inside_r <= contains_c;
    end
    if (cmd.out_load) begin
      m_tuser <= status_r;
      m_tdata <= {7'b0, frees, allocs, peak, allocated, inside_r, free_space_c, res_r};
    end
  end

  // pool state and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= 32'd0;
      pool_bytes  <= 32'd0;
      bump        <= 32'd0;
      allocated   <= 32'd0;
      peak        <= 32'd0;
      allocs      <= 32'd0;
      frees       <= 32'd0;
      listed      <= 32'd0;
      live        <= '0;
      blocks_used <= '0;
      free_depth  <= '0;
      ptr         <= '0;
    end else begin
      if (cmd.setup_align) ptr <= free_depth;
      if (cmd.ptr_down)    ptr <= ptr_m1;
      if (cmd.ptr_up)      ptr <= ptr_p1;
      if (cmd.ptr_clear)   ptr <= '0;
      if (cmd.shift_wr)    ptr <= ptr_p1;

      if (cmd.reuse_wb) begin
        ptr <= ptr_m1;
        listed <= (listed >= nb) ? (listed - nb) : 32'd0;
        live[stk_q] <= 1'b1;
        allocated <= inuse_sum;
        if (inuse_sum > peak) peak <= inuse_sum;
        allocs <= allocs + 32'd1;
      end
      if (cmd.shift_end) begin
        free_depth <= free_depth - 1'b1;
      end
      if (cmd.bump_wb) begin
        live[blocks_used[IDX_W-1:0]] <= 1'b1;
        blocks_used <= blocks_used + 1'b1;
        allocated <= inuse_sum;
        if (inuse_sum > peak) peak <= inuse_sum;
        bump <= end_r[31:0];
        allocs <= allocs + 32'd1;
      end
      if (cmd.free_wb) begin
        frees <= frees + 32'd1;
        // every block returned: reclaim the whole pool
        if (reclaim) begin
          bump        <= pool_base;
          allocated   <= 32'd0;
          listed      <= 32'd0;
          blocks_used <= '0;
          free_depth  <= '0;
          live        <= '0;
        end else begin
          live[ptr[IDX_W-1:0]] <= 1'b0;
          free_depth <= free_depth + 1'b1;
          listed <= sat32({1'b0, listed} + {1'b0, nb});
          if (allocated >= nb) allocated <= allocated - nb;
        end
      end

      if (cfg_wr && cfg_index == REG_POOL_BASE)  pool_base  <= cfg_data;
      if (cfg_wr && cfg_index == REG_POOL_BYTES) pool_bytes <= cfg_data;
      if (do_reset) begin
        bump        <= cfg_wr && cfg_index == REG_POOL_BASE ? cfg_data : pool_base;
        allocated   <= 32'd0;
        listed      <= 32'd0;
        blocks_used <= '0;
        free_depth  <= '0;
        live        <= '0;
        allocs      <= 32'd0;
        frees       <= 32'd0;
      end
    end
  end

endmodule

@@ sv/bump_free_list_allocator.sv @@
`timescale 1ns / 1ps
// channel  | dir | handshake        | payload
// s_       | in  | tvalid / tready  | tuser action, tdata size, align, address
// m_       | out | tvalid / tready  | tuser status, tdata results and statistics
// cfg_     | in  | valid / ready    | index, data (pool base, pool size)
//
// one item at a time; query, contains, pool reset, zero size and free of zero go from decode straight to output
// alloc by reuse: free-stack scan from the top, reuse write-back, then each stack entry above is moved down
// alloc by bump: free-stack scan finds no fit, then the bump end is computed and checked
// free: scan of the block table for the address; the table and stack memories
// (one read port each, registered) set the per-entry cost
// rst is synchronous; the tables need no clearing pass, counts guard them
// a result waiting in the output register holds off only the final step
module bump_free_list_allocator import bfla_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [31:0] req_size, [48:32] req_align, [80:49] address, rest zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [2:0] action
  input  logic [2:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] result_address, [63:32] free_space, [64] inside_pool,
  // [96:65] bytes_in_use, [128:97] peak_bytes, [160:129] alloc_count,
  // [192:161] free_count, rest zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [2:0] status
  output logic [2:0]            m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller sequences the scans, datapath holds tables and statistics
  bfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfla_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

`ifndef SYNTHESIS
  // one item in flight: no second transfer straight after the first
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  // a failed request never hands out an address
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[31:0] == 32'd0))
    else $error("address given with failing status");

  // in-use bytes never above the recorded peak
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[96:65] <= m_tdata[128:97]))
    else $error("bytes in use exceed peak");

  // a reuse write-back never comes with a bump or free write-back
  assert property (@(posedge clk) disable iff (rst)
    cmd.reuse_wb |-> !(cmd.bump_wb || cmd.free_wb))
    else $error("conflicting write-back commands");
`endif

endmodule
